// File: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SWTX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWTX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define SWTX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SWTX_ASSERT(lbl, clk, rstn, prop, msg)
`define SWTX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SWTX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/swtx_pkg.sv
package swtx_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int ADDR_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int SAMPLE_WIDTH = 32;
    localparam int SUM_W        = 39;
    localparam int LEN_W        = 7;
    localparam int ENTRY_W      = CNT_W + SAMPLE_WIDTH;
    localparam int TDATA_IN_W   = 32;
    localparam int TDATA_OUT_W  = 40;

    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_TOP_COUNT  = 1'b1;

    typedef struct packed {
        logic accept;
        logic key_sample;
        logic ev_lat;
        logic sweep_clr;
        logic sweep;
        logic ev_wr;
        logic in_wr;
        logic sum_rd;
        logic sum_lat;
        logic sum_mul;
        logic sum_acc;
        logic sum_next;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic evict_needed;
        logic sweep_last;
        logic will_fill;
        logic entry_empty;
        logic sum_last;
        logic out_busy;
        logic fill_over;
    } sts_t;

endpackage

// File: sv/swtx_ram.sv
module swtx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/swtx_dp.sv
module swtx_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swtx_pkg::cmd_t                      cmd,
    output swtx_pkg::sts_t                      sts,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [swtx_pkg::LEN_W-1:0]          cfg_wdata,
    input  logic [swtx_pkg::TDATA_IN_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swtx_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    localparam int AW = swtx_pkg::ADDR_W;
    localparam int CW = swtx_pkg::CNT_W;
    localparam int SW = swtx_pkg::SAMPLE_WIDTH;
    localparam int LW = swtx_pkg::LEN_W;
    localparam int XW = swtx_pkg::SUM_W;
    localparam int EW = swtx_pkg::ENTRY_W;
    localparam int WM = swtx_pkg::WINDOW_MAX;

    logic [LW-1:0] win_len_reg, top_cnt_reg, len_eff;
    logic signed [SW-1:0] sample_reg, key_reg;
    logic [AW-1:0] wp_reg, oldest;
    logic [CW-1:0] fill_reg;
    logic [WM-1:0] valid_reg;

    logic [CW-1:0] sweep_cnt_reg;
    logic          cmp_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          match_found_reg, empty_found_reg;
    logic [AW-1:0] match_idx_reg, empty_idx_reg;
    logic [CW-1:0] match_cnt_reg, rank_reg;

    logic [AW-1:0] i_reg;
    logic [CW-1:0] ci_reg;
    logic signed [SW-1:0] vi_reg;
    logic signed [XW-1:0] prod_reg, acc_reg;
    logic signed [XW-1:0] prod_full;

    logic          m_tvalid_reg;
    logic [XW-1:0] m_tdata_reg;

    logic [AW-1:0] tbl_raddr, tbl_waddr;
    logic [EW-1:0] tbl_rdata, tbl_wdata;
    logic          tbl_we;
    logic [SW-1:0] win_rdata;

    logic [CW-1:0]        ent_cnt;
    logic signed [SW-1:0] ent_val;
    logic                 ent_live, better;

    always_comb begin
        if (win_len_reg == '0) begin
            len_eff = LW'(1);
        end else if (win_len_reg > LW'(WM)) begin
            len_eff = LW'(WM);
        end else begin
            len_eff = win_len_reg;
        end
    end

    assign oldest    = wp_reg - fill_reg[AW-1:0];
    assign tbl_raddr = cmd.sum_rd ? i_reg : sweep_cnt_reg[AW-1:0];

    assign ent_cnt  = tbl_rdata[EW-1:SW];
    assign ent_val  = $signed(tbl_rdata[SW-1:0]);
    assign ent_live = valid_reg[rd_idx_reg] && (ent_cnt != '0);
    assign better   = (ent_cnt > ci_reg) || ((ent_cnt == ci_reg) && (ent_val > vi_reg));

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = match_idx_reg;
        tbl_wdata = {match_cnt_reg, key_reg};
        if (cmd.ev_wr && match_found_reg) begin
            tbl_we    = 1'b1;
            tbl_wdata = {match_cnt_reg - CW'(1), key_reg};
        end else if (cmd.in_wr) begin
            tbl_we = match_found_reg || empty_found_reg;
            if (match_found_reg) begin
                tbl_wdata = {match_cnt_reg + CW'(1), key_reg};
            end else begin
                tbl_waddr = empty_idx_reg;
                tbl_wdata = {CW'(1), key_reg};
            end
        end
    end

    swtx_ram #(.WIDTH(SW), .DEPTH(WM)) u_win_ram (
        .aclk  (aclk),
        .we    (cmd.in_wr),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .raddr (oldest),
        .rdata (win_rdata)
    );

    swtx_ram #(.WIDTH(EW), .DEPTH(WM)) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign prod_full = XW'($signed({1'b0, ci_reg})) * XW'(vi_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg  <= LW'(1);
            top_cnt_reg  <= LW'(1);
            wp_reg       <= '0;
            fill_reg     <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    swtx_pkg::REG_WINDOW_LEN: win_len_reg <= cfg_wdata;
                    swtx_pkg::REG_TOP_COUNT:  top_cnt_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept && s_tuser) begin
                wp_reg    <= '0;
                fill_reg  <= '0;
                valid_reg <= '0;
            end
            if (cmd.ev_wr) begin
                fill_reg <= fill_reg - CW'(1);
            end
            if (cmd.in_wr) begin
                wp_reg   <= wp_reg + AW'(1);
                fill_reg <= fill_reg + CW'(1);
                if (!match_found_reg && empty_found_reg) begin
                    valid_reg[empty_idx_reg] <= 1'b1;
                end
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rd_idx_reg <= tbl_raddr;
        if (cmd.accept) begin
            sample_reg <= $signed(s_tdata[SW-1:0]);
        end
        if (cmd.key_sample) begin
            key_reg <= sample_reg;
        end
        if (cmd.ev_lat) begin
            key_reg <= $signed(win_rdata);
        end
        if (cmd.sweep_clr) begin
            sweep_cnt_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            rank_reg        <= '0;
        end else if (cmd.sweep) begin
            sweep_cnt_reg <= sweep_cnt_reg + CW'(1);
            cmp_vld_reg   <= sweep_cnt_reg < CW'(WM);
            if (cmp_vld_reg) begin
                if (ent_live && (ent_val == key_reg) && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= rd_idx_reg;
                    match_cnt_reg   <= ent_cnt;
                end
                if (!ent_live && !empty_found_reg) begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= rd_idx_reg;
                end
                if (ent_live && (rd_idx_reg != i_reg) && better) begin
                    rank_reg <= rank_reg + CW'(1);
                end
            end
        end
        if (cmd.in_wr) begin
            i_reg   <= '0;
            acc_reg <= '0;
        end
        if (cmd.sum_lat) begin
            ci_reg <= ent_cnt;
            vi_reg <= ent_val;
        end
        if (cmd.sum_mul) begin
            prod_reg <= prod_full;
        end
        if (cmd.sum_acc && (rank_reg < top_cnt_reg)) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.sum_next) begin
            i_reg <= i_reg + AW'(1);
        end
        if (cmd.emit) begin
            m_tdata_reg <= acc_reg;
        end
    end

    assign sts.evict_needed = fill_reg >= len_eff;
    assign sts.sweep_last   = sweep_cnt_reg == CW'(WM);
    assign sts.will_fill    = (fill_reg + CW'(1)) == len_eff;
    assign sts.entry_empty  = !ent_live;
    assign sts.sum_last     = i_reg == AW'(WM - 1);
    assign sts.out_busy     = m_tvalid_reg && !m_tready;
    assign sts.fill_over    = fill_reg > CW'(WM);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(swtx_pkg::TDATA_OUT_W - XW){1'b0}}, m_tdata_reg};

endmodule

// File: sv/swtx_ctrl.sv
module swtx_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  swtx_pkg::sts_t sts,
    output swtx_pkg::cmd_t cmd
);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_EV_CHK  = 14'b00000000000010,
        ST_EV_RD   = 14'b00000000000100,
        ST_EV_LAT  = 14'b00000000001000,
        ST_EV_SWP  = 14'b00000000010000,
        ST_EV_WR   = 14'b00000000100000,
        ST_IN_SWP  = 14'b00000001000000,
        ST_IN_WR   = 14'b00000010000000,
        ST_SUM_RD  = 14'b00000100000000,
        ST_SUM_LAT = 14'b00001000000000,
        ST_SUM_SWP = 14'b00010000000000,
        ST_SUM_MUL = 14'b00100000000000,
        ST_SUM_ACC = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EV_CHK;
                end
            end
            ST_EV_CHK: begin
                cmd.sweep_clr = 1'b1;
                if (sts.evict_needed) begin
                    state_next = ST_EV_RD;
                end else begin
                    cmd.key_sample = 1'b1;
                    state_next     = ST_IN_SWP;
                end
            end
            ST_EV_RD: begin
                state_next = ST_EV_LAT;
            end
            ST_EV_LAT: begin
                cmd.ev_lat    = 1'b1;
                cmd.sweep_clr = 1'b1;
                state_next    = ST_EV_SWP;
            end
            ST_EV_SWP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_EV_WR;
                end
            end
            ST_EV_WR: begin
                cmd.ev_wr  = 1'b1;
                state_next = ST_EV_CHK;
            end
            ST_IN_SWP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IN_WR;
                end
            end
            ST_IN_WR: begin
                cmd.in_wr  = 1'b1;
                state_next = sts.will_fill ? ST_SUM_RD : ST_IDLE;
            end
            ST_SUM_RD: begin
                cmd.sum_rd = 1'b1;
                state_next = ST_SUM_LAT;
            end
            ST_SUM_LAT: begin
                cmd.sum_lat   = 1'b1;
                cmd.sweep_clr = 1'b1;
                if (sts.entry_empty) begin
                    cmd.sum_next = 1'b1;
                    state_next   = sts.sum_last ? ST_DONE : ST_SUM_RD;
                end else begin
                    state_next = ST_SUM_SWP;
                end
            end
            ST_SUM_SWP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_SUM_MUL;
                end
            end
            ST_SUM_MUL: begin
                cmd.sum_mul = 1'b1;
                state_next  = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                cmd.sum_acc  = 1'b1;
                cmd.sum_next = 1'b1;
                state_next   = sts.sum_last ? ST_DONE : ST_SUM_RD;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sliding_window_top_x_frequency_sum_top.sv
// one sample at a time; insert and each eviction are table sweeps
// with a full window the x-sum reads every table entry and sweeps the table for each live one
// result registered, next sample taken while it waits
// synchronous active-low reset: empty window and table, window_len = 1, top_count = 1
`include "assert_macros.svh"

module sliding_window_top_x_frequency_sum (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [swtx_pkg::TDATA_IN_W-1:0]     s_tdata,  // sample_value
    input  logic                                s_tuser,  // restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [swtx_pkg::TDATA_OUT_W-1:0]    m_tdata,  // x_sum, zero pad
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [swtx_pkg::LEN_W-1:0]          cfg_wdata
);

    swtx_pkg::cmd_t cmd;
    swtx_pkg::sts_t sts;

    swtx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swtx_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `SWTX_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, !sts.out_busy, "emit into busy output")
    `SWTX_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, cmd.accept, !s_tready, "ready after accept")
    `SWTX_ASSERT(a_fill_bound, aclk, aresetn, !sts.fill_over, "window fill beyond capacity")

endmodule

// File: test/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 6000;
    localparam longint CYCLE_LIMIT = 12_000_000;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [swtx_pkg::TDATA_IN_W-1:0]   s_tdata = '0;   // sample_value
    logic                              s_tuser = 1'b0; // restart
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [swtx_pkg::TDATA_OUT_W-1:0]  m_tdata;        // x_sum, zero pad
    logic                              cfg_we = 1'b0;
    logic                              cfg_index = swtx_pkg::REG_WINDOW_LEN;
    logic [swtx_pkg::LEN_W-1:0]        cfg_wdata = '0;

    sliding_window_top_x_frequency_sum dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic signed [swtx_pkg::SAMPLE_WIDTH-1:0] window_q[$];
    logic [swtx_pkg::LEN_W-1:0]               win_len_reg = 7'd1;
    logic [swtx_pkg::LEN_W-1:0]               top_cnt_reg = 7'd1;
    logic signed [swtx_pkg::SUM_W-1:0]        pending_sums[$];

    int     fail_count = 0;
    int     sent_count = 0;
    int     result_count = 0;
    int     restart_count = 0;
    longint cycle_count = 0;
    bit     steady = 1'b0;
    bit     hold_request = 1'b0;
    logic [31:0] pool[64];

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic signed [swtx_pkg::SUM_W-1:0] top_x_sum();
        int                                 counts[int];
        int                                 vals[$];
        int                                 rank;
        int                                 top;
        logic signed [swtx_pkg::SUM_W-1:0]  acc;
        acc = '0;
        foreach (window_q[k]) begin
            if (counts.exists(window_q[k])) begin
                counts[window_q[k]]++;
            end else begin
                counts[window_q[k]] = 1;
                vals.insert(vals.size(), window_q[k]);
            end
        end
        top = top_cnt_reg;
        foreach (vals[i]) begin
            rank = 0;
            foreach (vals[j]) begin
                if (j != i && (counts[vals[j]] > counts[vals[i]] ||
                    (counts[vals[j]] == counts[vals[i]] && vals[j] > vals[i]))) begin
                    rank++;
                end
            end
            if (rank < top) begin
                acc += swtx_pkg::SUM_W'(counts[vals[i]]) *
                       swtx_pkg::SUM_W'(signed'(vals[i]));
            end
        end
        return acc;
    endfunction

    // returns 1 if the window is full after the sample
    function automatic bit take_sample(input logic [31:0] v, input bit rs);
        int len;
        len = win_len_reg;
        if (len == 0) begin
            len = 1;
        end
        if (len > swtx_pkg::WINDOW_MAX) begin
            len = swtx_pkg::WINDOW_MAX;
        end
        if (rs) begin
            window_q.delete();
        end
        while (window_q.size() >= len) begin
            void'(window_q.pop_front());
        end
        window_q.insert(window_q.size(), v);
        return window_q.size() == len;
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(input logic [31:0] v, input bit rs,
                               input bit typed,
                               input logic signed [swtx_pkg::SUM_W-1:0] typed_sum);
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= rs;
        do @(posedge aclk); while (!s_tready);
        if (take_sample(v, rs)) begin
            pending_sums.insert(pending_sums.size(), typed ? typed_sum : top_x_sum());
        end
        sent_count++;
        if (rs) begin
            restart_count++;
        end
        @(negedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [swtx_pkg::LEN_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == swtx_pkg::REG_WINDOW_LEN) begin
            win_len_reg = val;
        end else begin
            top_cnt_reg = val;
        end
    endtask

    task automatic run_random(input logic [swtx_pkg::LEN_W-1:0] wl,
                              input logic [swtx_pkg::LEN_W-1:0] tc,
                              input int n, input int npool);
        logic [31:0] v;
        write_register(swtx_pkg::REG_WINDOW_LEN, wl);
        write_register(swtx_pkg::REG_TOP_COUNT, tc);
        for (int i = 0; i < npool; i++) begin
            case ($urandom_range(5))
                0: pool[i] = 32'h8000_0000;
                1: pool[i] = 32'h7fff_ffff;
                2: pool[i] = $urandom_range(7) - 3;
                default: pool[i] = $urandom;
            endcase
        end
        for (int i = 0; i < n; i++) begin
            v = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(npool - 1)];
            send_sample(v, $urandom_range(49) == 0, 1'b0, '0);
        end
    endtask

    typedef struct {
        logic [31:0]                       value;
        bit                                restart;
        bit                                typed;
        logic signed [swtx_pkg::SUM_W-1:0] sum;
    } stim_row_t;

    // first rows run with the reset settings: window of one, so the sum is the sample
    localparam int N_TYPED = 8;
    stim_row_t directed[22] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 39'sd0},
        '{32'h0000_0001, 1'b0, 1'b1, 39'sd1},
        '{32'hffff_ffff, 1'b0, 1'b1, -39'sd1},
        '{32'h7fff_ffff, 1'b0, 1'b1, 39'sd2147483647},
        '{32'h8000_0000, 1'b0, 1'b1, -39'sd2147483648},
        '{32'h5555_5555, 1'b1, 1'b1, 39'sd1431655765},
        '{32'haaaa_aaaa, 1'b0, 1'b1, -39'sd1431655766},
        '{32'h0000_0007, 1'b1, 1'b1, 39'sd7},
        // window 4, top 2: ties, restart with a full window, extremes
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 1'b0, 1'b0, '0},
        '{32'h0000_0009, 1'b1, 1'b0, '0},
        '{32'h0000_0009, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'h7fff_ffff, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'h8000_0000, 1'b0, 1'b0, '0},
        '{32'hffff_fffe, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, '0}
    };

    // receiver side, with one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 30000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || $urandom_range(99) >= 38;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unexpected x_sum %0d",
                    $signed(m_tdata[swtx_pkg::SUM_W-1:0])));
            end else if (m_tdata[swtx_pkg::SUM_W-1:0] !== pending_sums[0]) begin
                report_mismatch($sformatf("x_sum got %0d want %0d",
                    $signed(m_tdata[swtx_pkg::SUM_W-1:0]), pending_sums[0]));
                void'(pending_sums.pop_front());
            end else begin
                void'(pending_sums.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL sliding_window_top_x_frequency_sum");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            if (i == N_TYPED) begin
                write_register(swtx_pkg::REG_WINDOW_LEN, 7'd4);
                write_register(swtx_pkg::REG_TOP_COUNT, 7'd2);
            end
            send_sample(directed[i].value, directed[i].restart,
                        directed[i].typed, directed[i].sum);
        end

        run_random(7'd64, 7'd3, 150, 4);
        steady = 1'b1;
        run_random(7'd5, 7'd2, 200, 8);
        steady = 1'b0;
        run_random(7'd127, 7'd127, 40, 64);
        run_random(7'd0, 7'd0, 100, 5);
        run_random(7'd3, 7'd64, 200, 6);
        run_random(7'd20, 7'd1, 200, 10);
        hold_request = 1'b1;
        run_random(7'd64, 7'd64, 150, 16);
        run_random(7'd2, 7'd5, 150, 64);

        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d samples sent (%0d restarts), %0d sums checked", sent_count,
                 restart_count, result_count);
        $display("window lengths 0..127 and top counts 0..127, incl. shrink and grow");
        if (fail_count == 0) begin
            $display("PASS sliding_window_top_x_frequency_sum");
        end else begin
            $display("FAIL sliding_window_top_x_frequency_sum");
        end
        $finish;
    end

endmodule
